### hw/rtl/synth_voice_allocator_core_defines.svh
// Assertion macros shared by the voice allocator checkers.
// Expects clk and rst to be visible where a macro is used.
`ifndef SYNTH_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SVA_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice allocator check failed");

// Next-cycle implication, disabled while in reset.
`define SVA_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice allocator check failed");

`endif

### hw/rtl/sva_pkg.sv
// Shared types and constants for the voice allocator.
// No dependencies; imported by every module of the block.
package sva_pkg;

  localparam int NUM_VOICES = 16;
  localparam int VIDX_W     = $clog2(NUM_VOICES);
  localparam int CNT_W      = VIDX_W + 1;
  localparam int NOTE_W     = 7;
  localparam int AGE_W      = 32;
  localparam int MASK_W     = 16;
  localparam int VOUT_W     = 4;
  localparam int MAXV_W     = 5;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [1:0] REQ_NOTE_ON    = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF   = 2'd1;
  localparam logic [1:0] REQ_VOICE_DONE = 2'd2;

  localparam logic REG_MAX_VOICES = 1'b0;
  localparam logic REG_POLY_MODE  = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [NOTE_W-1:0] note_number;
    logic [3:0]        done_voice;
  } req_t;

  typedef struct packed {
    logic [VOUT_W-1:0] assigned_voice;
    logic              was_stolen;
    logic [MASK_W-1:0] release_mask;
  } rsp_t;

  typedef struct packed {
    logic [MAXV_W-1:0] max_voices;
    logic              poly_mode;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/sva_regs.sv
// APB-style configuration registers: max_voices at 0x0, poly_mode at 0x4.
// Depends on sva_pkg.
module sva_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sva_pkg::PADDR_W-1:0]  paddr,
  input  logic [sva_pkg::PDATA_W-1:0]  pwdata,
  output logic [sva_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output sva_pkg::cfg_t                cfg
);
  import sva_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{max_voices: MAXV_W'(NUM_VOICES), poly_mode: 1'b1};
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAX_VOICES: cfg.max_voices <= pwdata[MAXV_W-1:0];
        REG_POLY_MODE:  cfg.poly_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_VOICES: prdata = PDATA_W'(cfg.max_voices);
      REG_POLY_MODE:  prdata = PDATA_W'(cfg.poly_mode);
      default:        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/sva_ctrl.sv
// Controller: accept, scan the voice table, then commit one result.
// Depends on sva_pkg; drives the datapath through dp_cmd_t.
module sva_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  sva_pkg::dp_sts_t sts,
  output sva_pkg::dp_cmd_t cmd
);
  import sva_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready  = (state == ST_IDLE);
  assign cmd.start  = (state == ST_IDLE) && req_valid;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_FIN) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_SCAN;
      ST_SCAN: if (sts.scan_done) state_next = ST_FIN;
      ST_FIN:  if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/sva_dp.sv
// Datapath: voice table (active flops plus note/age memory), scan
// accumulators, age counter and the output register. Depends on sva_pkg.
module sva_dp (
  input  logic             clk,
  input  logic             rst,
  input  sva_pkg::cfg_t    cfg,
  input  sva_pkg::req_t    req_data,
  input  sva_pkg::dp_cmd_t cmd,
  output sva_pkg::dp_sts_t sts,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output sva_pkg::rsp_t    rsp_data
);
  import sva_pkg::*;

  localparam int WORD_W = NOTE_W + AGE_W;

  // note and age per voice; not reset, and the scan reads every entry below its limit
  logic [WORD_W-1:0]     mem [NUM_VOICES];
  logic [NUM_VOICES-1:0] active;
  logic [AGE_W-1:0]      age_counter;

  req_t              req_q;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  ptr;
  logic              rd_vld;
  logic [VIDX_W-1:0] rd_idx;
  logic [WORD_W-1:0] rd_data;
  logic [NOTE_W-1:0] rd_note;
  logic [AGE_W-1:0]  rd_age;

  logic              found_free;
  logic [VIDX_W-1:0] free_idx;
  logic              found_note;
  logic [VIDX_W-1:0] note_idx;
  logic [VIDX_W-1:0] best_idx;
  logic [AGE_W-1:0]  best_age;
  logic [MASK_W-1:0] mask;

  logic [CNT_W-1:0]  lim_clamped;
  logic [CNT_W-1:0]  limit_next;
  logic [VIDX_W-1:0] choice;
  logic [AGE_W-1:0]  age_inc;
  logic              done_ok;
  logic              wr_voice;

  assign rd_note = rd_data[WORD_W-1:AGE_W];
  assign rd_age  = rd_data[AGE_W-1:0];
  assign age_inc = age_counter + AGE_W'(1);
  assign done_ok = (32'(req_q.done_voice) < NUM_VOICES);

  assign sts.scan_done = (ptr == limit) && !rd_vld;
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    if (cfg.max_voices == '0) begin
      lim_clamped = CNT_W'(1);
    end else if (32'(cfg.max_voices) > NUM_VOICES) begin
      lim_clamped = CNT_W'(NUM_VOICES);
    end else begin
      lim_clamped = CNT_W'(cfg.max_voices);
    end
  end

  always_comb begin
    priority if (req_data.req_type == REQ_NOTE_ON && cfg.poly_mode) begin
      limit_next = lim_clamped;
    end else if (req_data.req_type == REQ_NOTE_OFF) begin
      limit_next = CNT_W'(NUM_VOICES);
    end else begin
      limit_next = '0;
    end
  end

  // mono mode takes voice 0; otherwise free voice beats same note, which beats oldest
  always_comb begin
    priority if (!cfg.poly_mode) begin
      choice = '0;
    end else if (found_free) begin
      choice = free_idx;
    end else if (found_note) begin
      choice = note_idx;
    end else begin
      choice = best_idx;
    end
  end

  assign wr_voice = cmd.commit && (req_q.req_type == REQ_NOTE_ON);

  always_ff @(posedge clk) begin
    if (wr_voice) begin
      mem[choice] <= {req_q.note_number, age_inc};
    end
    if (cmd.scan && ptr != limit) begin
      rd_data <= mem[ptr[VIDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= '0;
      age_counter <= '0;
      ptr         <= '0;
      limit       <= '0;
      rd_vld      <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.start) begin
        ptr    <= '0;
        limit  <= limit_next;
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        if (ptr != limit) begin
          ptr    <= ptr + CNT_W'(1);
          rd_vld <= 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
      end
      if (wr_voice) begin
        active[choice] <= 1'b1;
        age_counter    <= age_inc;
      end else if (cmd.commit && req_q.req_type == REQ_VOICE_DONE && done_ok) begin
        active[VIDX_W'(req_q.done_voice)] <= 1'b0;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request, scan accumulators and result payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q      <= req_data;
      found_free <= 1'b0;
      found_note <= 1'b0;
      free_idx   <= '0;
      note_idx   <= '0;
      best_idx   <= '0;
      best_age   <= '0;
      mask       <= '0;
    end else if (rd_vld) begin
      if (!found_free && !active[rd_idx]) begin
        found_free <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (!found_note && rd_note == req_q.note_number) begin
        found_note <= 1'b1;
        note_idx   <= rd_idx;
      end
      if (rd_idx == '0 || rd_age < best_age) begin
        best_idx <= rd_idx;
        best_age <= rd_age;
      end
      if (active[rd_idx] && rd_note == req_q.note_number && 32'(rd_idx) < MASK_W) begin
        mask <= mask | (MASK_W'(1) << rd_idx);
      end
    end
    if (cmd.scan) begin
      rd_idx <= ptr[VIDX_W-1:0];
    end
    if (cmd.commit) begin
      if (req_q.req_type == REQ_NOTE_ON) begin
        rsp_data <= '{assigned_voice: VOUT_W'(choice), was_stolen: active[choice],
                      release_mask: '0};
      end else if (req_q.req_type == REQ_NOTE_OFF) begin
        rsp_data <= '{assigned_voice: '0, was_stolen: 1'b0, release_mask: mask};
      end else begin
        rsp_data <= '0;
      end
    end
  end

endmodule

### hw/rtl/synth_voice_allocator_core.sv
// Voice allocator for a polyphonic synthesizer.
// Request channel (req_valid/req_ready/req_data) takes note-on, note-off
// and voice-done events; response channel (rsp_valid/rsp_ready/rsp_data)
// returns one result per event: the chosen voice and steal flag on
// note-on, a release mask on note-off, all zero otherwise.
// One event is processed at a time. A note-on in poly mode scans the
// first max_voices entries (clamped to 1..NUM_VOICES) through the single
// memory read port; the response becomes valid in the same cycle that
// req_ready returns for the next request. Note-off scans all NUM_VOICES
// entries; mono note-on, voice-done and unused codes skip the scan.
// The response sits in an output register; the next request is accepted
// while it waits, but the following commit holds until rsp_ready frees it.
// Reset (rst, synchronous) clears all active flags, the age counter and
// both channels' valid state; max_voices returns to 16, poly_mode to 1.
// Configuration is to be written over the APB port only while no
// transaction is open; the block itself does not enforce this.
// Depends on sva_pkg, sva_regs, sva_ctrl and sva_dp.
module synth_voice_allocator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sva_pkg::PADDR_W-1:0]  paddr,
  input  logic [sva_pkg::PDATA_W-1:0]  pwdata,
  output logic [sva_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  sva_pkg::req_t                req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output sva_pkg::rsp_t                rsp_data
);
  import sva_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  sva_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sva_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

### hw/rtl/sva_checker.sv
// Port-level checks for the voice allocator, bound to the top level.
// Depends on sva_pkg and synth_voice_allocator_core_defines.svh.
`include "synth_voice_allocator_core_defines.svh"

module sva_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sva_pkg::rsp_t rsp_data
);
  import sva_pkg::*;

  // a stalled response keeps its payload
  `SVA_CHK_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // one transaction in flight: busy right after an accept
  `SVA_CHK_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  // a release mask only comes with an empty voice assignment
  `SVA_CHK_IMP(a_mask_exclusive, rsp_valid && rsp_data.release_mask != '0,
               rsp_data.assigned_voice == '0 && !rsp_data.was_stolen)

  // leaving reset: idle and no response pending
  `SVA_CHK_IMP(a_reset_idle, $past(rst), req_ready && !rsp_valid)

endmodule

bind synth_voice_allocator_core sva_checker u_sva_checker (.*);

### test/testbench.sv
// Self-checking bench for synth_voice_allocator_core: table-driven directed events,
// then random note-on/off/done/unused traffic across several voice-count and mode settings.
// Depends on sva_pkg and the RTL of the allocator only.
module testbench;
  import sva_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE      = NUM_VOICES + 4;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_PRINTS  = 40;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    req_t        req;
    logic        fixed;
    rsp_t        rsp;
    logic        sel;
    logic [4:0]  val;
  } dir_row_t;

  typedef struct {
    logic fixed;
    rsp_t rsp;
  } table_rsp_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                req_valid;
  logic                req_ready;
  req_t                req_data;
  logic                rsp_valid;
  logic                rsp_ready;
  rsp_t                rsp_data;

  // allocator shadow state
  logic               voice_on    [NUM_VOICES];
  logic [NOTE_W-1:0]  voice_key   [NUM_VOICES];
  logic [AGE_W-1:0]   voice_stamp [NUM_VOICES];
  logic [AGE_W-1:0]   stamp_count;
  logic [MAXV_W-1:0]  cfg_max;
  logic               cfg_poly;

  rsp_t        voice_results_q [$];
  table_rsp_t  table_rsp_q [$];
  dir_row_t    dir_rows [$];
  logic [NOTE_W-1:0] note_pool [6];

  logic [MAXV_W-1:0] ph_max  [NUM_PHASES] = '{16, 1, 0, 31, 5, 3, 17, 16, 8, 2};
  logic              ph_poly [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1};

  int   errors;
  int   rsp_total = 0;
  int   idle_cycles = 0;
  int   n_on, n_steal, n_off, n_done, n_unused;
  logic idle_on;
  logic held;

  synth_voice_allocator_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, rsp_total);
    errors++;
  endtask

  // Allocation predictor; updates the shadow voice table.
  function automatic rsp_t allocate_voice(input req_t r);
    rsp_t o;
    int   lim;
    int   v;
    logic found;
    o = '0;
    case (r.req_type)
      REQ_NOTE_ON: begin
        v = 0;
        if (cfg_poly) begin
          lim = (cfg_max == 0) ? 1 : (cfg_max > NUM_VOICES) ? NUM_VOICES : int'(cfg_max);
          found = 1'b0;
          for (int i = 0; i < lim; i++)
            if (!found && !voice_on[i]) begin
              v = i;
              found = 1'b1;
            end
          for (int i = 0; i < lim; i++)
            if (!found && voice_key[i] == r.note_number) begin
              v = i;
              found = 1'b1;
            end
          if (!found)
            for (int i = 1; i < lim; i++)
              if (voice_stamp[i] < voice_stamp[v]) v = i;
        end
        o.was_stolen = voice_on[v];
        stamp_count = stamp_count + 1;
        voice_on[v] = 1'b1;
        voice_key[v] = r.note_number;
        voice_stamp[v] = stamp_count;
        o.assigned_voice = VOUT_W'(v);
      end
      REQ_NOTE_OFF: begin
        for (int i = 0; i < NUM_VOICES; i++)
          if (voice_on[i] && voice_key[i] == r.note_number && i < MASK_W)
            o.release_mask[i] = 1'b1;
      end
      REQ_VOICE_DONE: begin
        if (r.done_voice < NUM_VOICES) voice_on[r.done_voice] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t random_event();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 50)      r.req_type = REQ_NOTE_ON;
    else if (pick < 70) r.req_type = REQ_NOTE_OFF;
    else if (pick < 95) r.req_type = REQ_VOICE_DONE;
    else                r.req_type = REQ_UNUSED;
    // mostly a small pool so note matches and releases actually hit
    if ($urandom_range(99) < 35) r.note_number = NOTE_W'($urandom_range(127));
    else                         r.note_number = note_pool[$urandom_range(5)];
    r.done_voice = 4'($urandom_range(15));
    return r;
  endfunction

  task automatic add_event(input logic [1:0] kind, input int note, input int dv);
    dir_row_t row;
    row = '{kind: ROW_EVENT, req: '0, fixed: 1'b0, rsp: '0, sel: 1'b0, val: '0};
    row.req.req_type = kind;
    row.req.note_number = NOTE_W'(note);
    row.req.done_voice = 4'(dv);
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_known(input logic [1:0] kind, input int note, input int dv,
                           input int voice, input logic stolen, input int mask);
    dir_row_t row;
    row = '{kind: ROW_EVENT, req: '0, fixed: 1'b1, rsp: '0, sel: 1'b0, val: '0};
    row.req.req_type = kind;
    row.req.note_number = NOTE_W'(note);
    row.req.done_voice = 4'(dv);
    row.rsp.assigned_voice = VOUT_W'(voice);
    row.rsp.was_stolen = stolen;
    row.rsp.release_mask = MASK_W'(mask);
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_cfg(input logic sel, input logic [4:0] val);
    dir_row_t row;
    row = '{kind: ROW_CFG, req: '0, fixed: 1'b0, rsp: '0, sel: sel, val: val};
    dir_rows = {dir_rows, row};
  endtask

  task automatic send_event(input req_t r, input logic fixed, input rsp_t want);
    table_rsp_t t;
    while (idle_on && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    t.fixed = fixed;
    t.rsp = want;
    table_rsp_q = {table_rsp_q, t};
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Drains the block, then writes one register through a setup and an access phase.
  task automatic write_reg(input logic sel, input logic [4:0] val);
    req_valid <= 1'b0;
    @(posedge clk);
    while (voice_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {27'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_MAX_VOICES) cfg_max = val;
    else                       cfg_poly = val[0];
  endtask

  // Result checker and expectation builder
  always @(posedge clk) begin : monitor
    rsp_t       want;
    table_rsp_t t;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        rsp_total <= rsp_total + 1;
        if (voice_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(rsp_data), 32'd0);
        end else begin
          want = voice_results_q.pop_front();
          if (rsp_data.assigned_voice !== want.assigned_voice)
            report_mismatch("assigned_voice", 32'(rsp_data.assigned_voice),
                            32'(want.assigned_voice));
          if (rsp_data.was_stolen !== want.was_stolen)
            report_mismatch("was_stolen", 32'(rsp_data.was_stolen), 32'(want.was_stolen));
          if (rsp_data.release_mask !== want.release_mask)
            report_mismatch("release_mask", 32'(rsp_data.release_mask),
                            32'(want.release_mask));
        end
      end
      if (req_valid && req_ready) begin
        want = allocate_voice(req_data);
        case (req_data.req_type)
          REQ_NOTE_ON: begin
            n_on++;
            if (want.was_stolen) n_steal++;
          end
          REQ_NOTE_OFF:   n_off++;
          REQ_VOICE_DONE: n_done++;
          default:        n_unused++;
        endcase
        t = table_rsp_q.pop_front();
        if (t.fixed) want = t.rsp;
        voice_results_q = {voice_results_q, want};
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Response side: random backpressure plus one long hold-off
  initial begin
    held = 1'b0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && rsp_total >= HOLD_AT) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  initial begin
    req_t r;
    rsp_t none;
    errors = 0;
    n_on = 0; n_steal = 0; n_off = 0; n_done = 0; n_unused = 0;
    idle_on = 1'b1;
    none = '0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_on[i] = 1'b0;
      voice_key[i] = '0;
      voice_stamp[i] = '0;
    end
    stamp_count = '0;
    cfg_max = MAXV_W'(16);
    cfg_poly = 1'b1;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_valid <= 1'b0;
    req_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, unused code, lowest-free allocation, masks
    add_known(REQ_NOTE_OFF,   60,  0, 0, 1'b0, 16'h0000);
    add_known(REQ_UNUSED,     127, 15, 0, 1'b0, 16'h0000);
    add_known(REQ_NOTE_ON,    0,   0, 0, 1'b0, 16'h0000);
    add_known(REQ_NOTE_ON,    127, 0, 1, 1'b0, 16'h0000);
    add_known(REQ_NOTE_OFF,   127, 0, 0, 1'b0, 16'h0002);
    add_known(REQ_NOTE_ON,    127, 0, 2, 1'b0, 16'h0000);
    add_known(REQ_NOTE_OFF,   127, 0, 0, 1'b0, 16'h0006);
    add_known(REQ_VOICE_DONE, 0,   1, 0, 1'b0, 16'h0000);
    add_known(REQ_NOTE_OFF,   127, 0, 0, 1'b0, 16'h0004);
    add_known(REQ_NOTE_ON,    64,  0, 1, 1'b0, 16'h0000);
    add_known(REQ_VOICE_DONE, 0,   15, 0, 1'b0, 16'h0000);
    add_known(REQ_VOICE_DONE, 0,   0, 0, 1'b0, 16'h0000);
    add_known(REQ_NOTE_OFF,   0,   0, 0, 1'b0, 16'h0000);
    // two-voice window: free, oldest steal, same-note steal
    add_cfg(REG_MAX_VOICES, 5'd2);
    add_event(REQ_NOTE_ON, 5,  0);
    add_event(REQ_NOTE_ON, 10, 0);
    add_event(REQ_NOTE_ON, 5,  0);
    add_event(REQ_NOTE_ON, 77, 0);
    // mono
    add_cfg(REG_POLY_MODE, 5'd0);
    add_event(REQ_NOTE_ON,  127, 0);
    add_event(REQ_NOTE_OFF, 127, 0);
    add_known(REQ_UNUSED, 0, 0, 0, 1'b0, 16'h0000);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].sel, dir_rows[i].val);
      else send_event(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_MAX_VOICES, ph_max[ph]);
      write_reg(REG_POLY_MODE, {4'd0, ph_poly[ph]});
      foreach (note_pool[k]) note_pool[k] = NOTE_W'($urandom_range(127));
      idle_on = (ph != 7);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = random_event();
        send_event(r, 1'b0, none);
      end
    end
    idle_on = 1'b1;

    req_valid <= 1'b0;
    @(posedge clk);
    while (voice_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d note-ons (%0d steals), %0d note-offs, %0d voice-done, %0d unused",
             n_on, n_steal, n_off, n_done, n_unused);
    $display("events over %0d voice-count/mode settings; %0d mismatches.",
             NUM_PHASES + 2, errors);
    if (errors == 0 && voice_results_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
